[rtl/fpd_pkg.sv]
package fpd_pkg;

  // Fixed-point constants
  localparam int COEF_ONE   = 256;
  localparam int SLOW_SCALE = 218;
  localparam int FAST_SPEED = 200;
  localparam int POWER_MAX  = 255;

  // Configuration register indexes
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_GAIN_P = 2'd1;
  localparam logic [1:0] REG_GAIN_D = 2'd2;
  localparam logic [1:0] REG_COEF   = 2'd3;

  // Configuration reset values and target mask
  localparam logic [12:0] TARGET_RESET = 13'd3500;
  localparam logic [12:0] TARGET_MASK  = 13'h1FFF;
  localparam logic [15:0] GAIN_RESET   = 16'd256;
  localparam logic [8:0]  COEF_RESET   = 9'd128;

  // Program counter
  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] STEP_STOP = 4'd12;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Multiplier operand A: coefficients and gains
  typedef enum logic [2:0] {
    A_COEF,
    A_ICOEF,
    A_GP,
    A_GD,
    A_SCL
  } a_sel_t;

  // Multiplier operand B: error terms and halves of the sum
  typedef enum logic [2:0] {
    B_D,
    B_FR,
    B_ERR,
    B_RATE,
    B_LO,
    B_HI
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADDHI
  } acc_op_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ERR,
    ACT_RATE,
    ACT_OUT,
    ACT_ZERO
  } act_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_IF_STOP,
    JMP_END
  } jmp_t;

  typedef struct packed {
    a_sel_t               asel;
    b_sel_t               bsel;
    logic                 mul_en;
    acc_op_t              acc_op;
    act_t                 act;
    jmp_t                 jmp;
    logic [STEP_BITS-1:0] target;
  } ctrl_word_t;

  // Sequencer to datapath
  typedef struct packed {
    logic       step_en;
    ctrl_word_t cw;
  } seq_ctl_t;

  function automatic ctrl_word_t mk_cw(input a_sel_t a, input b_sel_t b, input logic m,
                                       input acc_op_t o, input act_t t, input jmp_t j,
                                       input logic [STEP_BITS-1:0] tg);
    ctrl_word_t w;
    w.asel   = a;
    w.bsel   = b;
    w.mul_en = m;
    w.acc_op = o;
    w.act    = t;
    w.jmp    = j;
    w.target = tg;
    return w;
  endfunction

  // Control program: filter, PD sum, speed scaling, output, or a zero result when stopped
  function automatic ctrl_word_t ucode_rom(input logic [STEP_BITS-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      4'd0:  w = mk_cw(A_COEF,  B_D,    1'b0, ACC_HOLD,  ACT_ERR,  JMP_IF_STOP, STEP_STOP);
      4'd1:  w = mk_cw(A_COEF,  B_D,    1'b1, ACC_HOLD,  ACT_NONE, JMP_NEXT,    '0);
      4'd2:  w = mk_cw(A_ICOEF, B_FR,   1'b1, ACC_LOAD,  ACT_NONE, JMP_NEXT,    '0);
      4'd3:  w = mk_cw(A_COEF,  B_D,    1'b0, ACC_ADD,   ACT_NONE, JMP_NEXT,    '0);
      4'd4:  w = mk_cw(A_COEF,  B_D,    1'b0, ACC_HOLD,  ACT_RATE, JMP_NEXT,    '0);
      4'd5:  w = mk_cw(A_GP,    B_ERR,  1'b1, ACC_HOLD,  ACT_NONE, JMP_NEXT,    '0);
      4'd6:  w = mk_cw(A_GD,    B_RATE, 1'b1, ACC_LOAD,  ACT_NONE, JMP_NEXT,    '0);
      4'd7:  w = mk_cw(A_COEF,  B_D,    1'b0, ACC_ADD,   ACT_NONE, JMP_NEXT,    '0);
      4'd8:  w = mk_cw(A_SCL,   B_LO,   1'b1, ACC_HOLD,  ACT_NONE, JMP_NEXT,    '0);
      4'd9:  w = mk_cw(A_SCL,   B_HI,   1'b1, ACC_LOAD,  ACT_NONE, JMP_NEXT,    '0);
      4'd10: w = mk_cw(A_COEF,  B_D,    1'b0, ACC_ADDHI, ACT_NONE, JMP_NEXT,    '0);
      4'd11: w = mk_cw(A_COEF,  B_D,    1'b0, ACC_HOLD,  ACT_OUT,  JMP_END,     '0);
      4'd12: w = mk_cw(A_COEF,  B_D,    1'b0, ACC_HOLD,  ACT_ZERO, JMP_END,     '0);
      default: w = mk_cw(A_COEF, B_D,   1'b0, ACC_HOLD,  ACT_NONE, JMP_END,     '0);
    endcase
    return w;
  endfunction

endpackage

[rtl/fpd_seq.sv]
module fpd_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              stop_cond,
  input  logic              out_free,
  output logic              busy,
  output fpd_pkg::seq_ctl_t seq_ctl
);
  import fpd_pkg::*;

  seq_state_t           state_r, state_nxt;
  logic [STEP_BITS-1:0] pc_r, pc_nxt;
  ctrl_word_t           cw;
  logic                 stall;

  assign cw    = ucode_rom(pc_r);
  // Hold a result step until the output register is free
  assign stall = ((cw.act == ACT_OUT) || (cw.act == ACT_ZERO)) && !out_free;

  // Next state and step
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = '0;
        end
      end
      SEQ_RUN: begin
        if (!stall) begin
          unique case (cw.jmp)
            JMP_IF_STOP: pc_nxt = stop_cond ? cw.target : pc_r + 1'b1;
            JMP_END:     state_nxt = SEQ_IDLE;
            default:     pc_nxt = pc_r + 1'b1;
          endcase
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    busy            = (state_r == SEQ_RUN);
    seq_ctl.cw      = cw;
    seq_ctl.step_en = (state_r == SEQ_RUN) && !stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

[rtl/filtered_pd_differential_drive.sv]
// The block takes one item at a time: in_ready is low while the control
// program runs, so a new item is accepted only once the last one is done.
// The steps of the control program on the single shared 17x18 multiplier
// set the throughput.
// The output register lets a new item in while a result waits.
// Reset (rst_n low, synchronous): registers to defaults, filter state cleared.
module filtered_pd_differential_drive #(
  parameter int POSITION_BITS = 13
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [POSITION_BITS-1:0] in_line_position,
  input  logic signed [8:0]        in_base_speed,
  input  logic                     in_robot_stopped,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [8:0]        out_left_motor,
  output logic signed [8:0]        out_right_motor,
  output logic signed [8:0]        out_correction,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_wdata
);
  import fpd_pkg::*;

  localparam int P  = POSITION_BITS;
  localparam int S  = P + 1;
  localparam int MB = (S + 1 > 18) ? S + 1 : 18;
  localparam int PW = 17 + MB;
  localparam int AW = (S + 25 > PW) ? S + 25 : PW;
  localparam logic signed [AW-1:0] PMAX_W = AW'(POWER_MAX);
  localparam logic signed [AW-1:0] PMIN_W = -PMAX_W;

  // Configuration
  logic [P-1:0]  tgt_r;
  logic [15:0]   gp_r, gd_r;
  logic [8:0]    coef_r;

  // Latched item
  logic [P-1:0]         pos_r;
  logic signed [8:0]    base_r;
  logic                 stop_r;

  // Filter state and working registers
  logic signed [S-1:0]  last_err_r, frate_r;
  logic signed [S-1:0]  err_r, rate_r;
  logic signed [S:0]    d_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;

  // Result register
  logic                 out_valid_r;
  logic signed [8:0]    left_r, right_r, corr_r;

  seq_ctl_t seq_ctl;
  logic     busy, in_acc, out_free, fire;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !busy;
  assign fire     = seq_ctl.step_en;

  fpd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .stop_cond(stop_r),
    .out_free (out_free),
    .busy     (busy),
    .seq_ctl  (seq_ctl)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= P'(TARGET_RESET);
      gp_r   <= GAIN_RESET;
      gd_r   <= GAIN_RESET;
      coef_r <= COEF_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TARGET: tgt_r  <= cfg_wdata[P-1:0] & P'(TARGET_MASK);
        REG_GAIN_P: gp_r   <= cfg_wdata;
        REG_GAIN_D: gd_r   <= cfg_wdata;
        REG_COEF:   coef_r <= cfg_wdata[8:0];
      endcase
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r  <= in_line_position;
      base_r <= in_base_speed;
      stop_r <= in_robot_stopped;
    end
  end

  // Error and its difference
  logic signed [S-1:0] err_c;
  logic signed [S:0]   d_c;
  assign err_c = $signed({1'b0, pos_r}) - $signed({1'b0, tgt_r});
  assign d_c   = (S+1)'(err_c) - (S+1)'(last_err_r);

  // Operand selection
  logic [8:0]           a_c, ia_c;
  logic                 fast;
  logic signed [16:0]   mul_a;
  logic signed [MB-1:0] mul_b;

  assign a_c  = (coef_r > 9'(COEF_ONE)) ? 9'(COEF_ONE) : coef_r;
  assign ia_c = 9'(COEF_ONE) - a_c;
  assign fast = base_r > 9'sd200;

  always_comb begin
    unique case (seq_ctl.cw.asel)
      A_COEF:  mul_a = {8'd0, a_c};
      A_ICOEF: mul_a = {8'd0, ia_c};
      A_GP:    mul_a = {1'b0, gp_r};
      A_GD:    mul_a = {1'b0, gd_r};
      A_SCL:   mul_a = fast ? 17'(SLOW_SCALE) : 17'(COEF_ONE);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (seq_ctl.cw.bsel)
      B_D:     mul_b = MB'(d_r);
      B_FR:    mul_b = MB'(frate_r);
      B_ERR:   mul_b = MB'(err_r);
      B_RATE:  mul_b = MB'(rate_r);
      B_LO:    mul_b = MB'({1'b0, acc_r[16:0]});
      B_HI:    mul_b = MB'($signed(acc_r[S+16:17]));
      default: mul_b = '0;
    endcase
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    if (fire && seq_ctl.cw.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      unique case (seq_ctl.cw.acc_op)
        ACC_LOAD:  acc_r <= AW'(prod_r);
        ACC_ADD:   acc_r <= acc_r + AW'(prod_r);
        ACC_ADDHI: acc_r <= acc_r + (AW'(prod_r) <<< 17);
        default:   acc_r <= acc_r;
      endcase
    end
  end

  // Filtered rate: truncate toward zero, saturate to state width
  logic signed [AW-1:0] rsum, rsh;
  logic                 rovf;
  logic signed [S-1:0]  rate_c;
  assign rsum   = acc_r + (acc_r[AW-1] ? AW'(255) : '0);
  assign rsh    = rsum >>> 8;
  assign rovf   = !((&rsh[AW-1:S-1]) || !(|rsh[AW-1:S-1]));
  assign rate_c = !rovf ? rsh[S-1:0] :
                  rsh[AW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};

  // Correction: truncate toward zero, saturate to power range
  logic signed [AW-1:0] csum, csh;
  logic signed [8:0]    corr_c;
  assign csum   = acc_r + (acc_r[AW-1] ? AW'(65535) : '0);
  assign csh    = csum >>> 16;
  assign corr_c = (csh > PMAX_W) ? 9'sd255 :
                  (csh < PMIN_W) ? -9'sd255 : csh[8:0];

  function automatic logic [8:0] sat_pwr(input logic signed [9:0] v);
    if (v > 10'sd255) begin
      return 9'd255;
    end else if (v < -10'sd255) begin
      return 9'h101;
    end else begin
      return v[8:0];
    end
  endfunction

  logic signed [9:0] lsum, rsub;
  assign lsum = 10'(base_r) + 10'(corr_c);
  assign rsub = 10'(base_r) - 10'(corr_c);

  // Working registers
  always_ff @(posedge clk) begin
    if (fire && (seq_ctl.cw.act == ACT_ERR)) begin
      err_r <= err_c;
      d_r   <= d_c;
    end
    if (fire && (seq_ctl.cw.act == ACT_RATE)) begin
      rate_r <= rate_c;
    end
  end

  // Advance filter state on running items only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      frate_r    <= '0;
    end else if (fire && (seq_ctl.cw.act == ACT_OUT)) begin
      last_err_r <= err_r;
      frate_r    <= rate_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && ((seq_ctl.cw.act == ACT_OUT) || (seq_ctl.cw.act == ACT_ZERO))) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (seq_ctl.cw.act == ACT_OUT)) begin
      left_r  <= sat_pwr(lsum);
      right_r <= sat_pwr(rsub);
      corr_r  <= corr_c;
    end else if (fire && (seq_ctl.cw.act == ACT_ZERO)) begin
      left_r  <= '0;
      right_r <= '0;
      corr_r  <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_motor  = left_r;
  assign out_right_motor = right_r;
  assign out_correction  = corr_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("block ready right after accepting an item");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_correction != -9'sd256 && out_left_motor != -9'sd256 &&
                   out_right_motor != -9'sd256))
    else $error("result outside saturation range");

  a_stop_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && seq_ctl.cw.act == ACT_ZERO) |=> ($stable(last_err_r) && $stable(frate_r)))
    else $error("stopped item changed filter state");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && seq_ctl.cw.act == ACT_ZERO) |=> (out_correction == 9'sd0 &&
                                              out_left_motor == 9'sd0))
    else $error("stopped item gave nonzero result");

  a_valid_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire))
    else $error("result appeared without a program step");

endmodule

[tb/filtered_pd_differential_drive_tb.sv]
`timescale 1ns / 100ps

module filtered_pd_differential_drive_tb;
  import fpd_pkg::*;

  localparam int POS_W = 13;
  localparam longint RATE_HI = (64'sd1 <<< POS_W) - 1;
  localparam longint RATE_LO = -(64'sd1 <<< POS_W);
  localparam int RAND_PHASES = 10;
  localparam int PHASE_TICKS = 103;

  typedef struct packed {
    logic signed [8:0] left;
    logic signed [8:0] right;
    logic signed [8:0] corr;
  } drive_t;

  // One line of the directed plan: a register write or a control tick
  typedef struct {
    bit                is_reg;
    logic [1:0]        idx;
    logic [15:0]       wdata;
    logic [POS_W-1:0]  pos;
    logic signed [8:0] base;
    logic              stop;
    bit                fixed;
    drive_t            fixed_drive;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [POS_W-1:0]        in_line_position;
  logic signed [8:0]       in_base_speed;
  logic                    in_robot_stopped;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [8:0]       out_left_motor;
  logic signed [8:0]       out_right_motor;
  logic signed [8:0]       out_correction;
  logic                    cfg_wr_en;
  logic [1:0]              cfg_index;
  logic [15:0]             cfg_wdata;

  // Controller copy: registers and filter state
  logic [POS_W-1:0] tgt_pos;
  logic [15:0]      kp;
  logic [15:0]      kd;
  logic [8:0]       lp_coef;
  longint           last_err;
  longint           filt_rate;

  drive_t pending_drive[$];
  plan_row_t plan[$];

  int  fail_cnt;
  int  results_seen;
  int  ticks_sent;
  int  stopped_sent;
  int  reg_writes;
  int  stall_left;
  bit  steady_flow;

  filtered_pd_differential_drive #(
    .POSITION_BITS(POS_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_line_position (in_line_position),
    .in_base_speed    (in_base_speed),
    .in_robot_stopped (in_robot_stopped),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_motor   (out_left_motor),
    .out_right_motor  (out_right_motor),
    .out_correction   (out_correction),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint sat_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Compute one tick's motor drive; running ticks also advance the filter state
  function automatic drive_t steer_predict(input logic [POS_W-1:0] pos,
                                           input logic signed [8:0] base,
                                           input logic stop);
    drive_t r;
    longint err, diff, a, rate, sum, corr;
    r = '0;
    if (stop) return r;
    err  = longint'(pos) - longint'(tgt_pos);
    diff = err - last_err;
    a    = (lp_coef > COEF_ONE) ? COEF_ONE : longint'(lp_coef);
    rate = sat_to((a * diff + (COEF_ONE - a) * filt_rate) / COEF_ONE, RATE_LO, RATE_HI);
    sum  = longint'(kp) * err + longint'(kd) * rate;
    sum  = sum * ((base > FAST_SPEED) ? SLOW_SCALE : COEF_ONE);
    corr = sat_to(sum / 65536, -POWER_MAX, POWER_MAX);
    r.left  = 9'(sat_to(longint'(base) + corr, -POWER_MAX, POWER_MAX));
    r.right = 9'(sat_to(longint'(base) - corr, -POWER_MAX, POWER_MAX));
    r.corr  = 9'(corr);
    filt_rate = rate;
    last_err  = sat_to(err, RATE_LO, RATE_HI);
    return r;
  endfunction

  function automatic plan_row_t tick_row(input int pos, input int base, input bit stop);
    plan_row_t r;
    r = '{default: '0};
    r.pos  = POS_W'(pos);
    r.base = 9'(base);
    r.stop = stop;
    return r;
  endfunction

  function automatic plan_row_t known_row(input int pos, input int base, input bit stop,
                                          input int l, input int rt, input int c);
    plan_row_t r;
    r = tick_row(pos, base, stop);
    r.fixed = 1'b1;
    r.fixed_drive.left  = 9'(l);
    r.fixed_drive.right = 9'(rt);
    r.fixed_drive.corr  = 9'(c);
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [15:0] data);
    plan_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.wdata  = data;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] gain_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 35) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 600));
  endfunction

  task automatic check_field(input string name, input logic signed [8:0] want,
                             input logic signed [8:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Present one tick and hold it until accepted
  task automatic send_tick(input logic [POS_W-1:0] pos, input logic signed [8:0] base,
                           input logic stop, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_line_position <= pos;
    in_base_speed    <= base;
    in_robot_stopped <= stop;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    if (stop) stopped_sent++;
  endtask

  // Stop sending and let every outstanding result drain
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET: tgt_pos = data[POS_W-1:0];
      REG_GAIN_P: kp = data;
      REG_GAIN_D: kd = data;
      REG_COEF:   lp_coef = data[8:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Receive side: check each accepted result, then pick the next stall
  always @(posedge clk) begin : rx_side
    drive_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result left %0d right %0d corr %0d", $time,
                 out_left_motor, out_right_motor, out_correction);
      end else begin
        want = pending_drive.pop_front();
        results_seen++;
        check_field("left motor", want.left, out_left_motor);
        check_field("right motor", want.right, out_right_motor);
        check_field("correction", want.corr, out_correction);
      end
    end
    if (steady_flow) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? gap_draw() : 0;
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stim
    plan_row_t row;
    drive_t    want;
    int        r, p, tv;
    logic [15:0] w;
    logic [POS_W-1:0] pos;
    logic signed [8:0] base;
    logic        stop;
    logic [POS_W-1:0] ph_tgt;
    logic [15:0] ph_kp, ph_kd;
    logic [8:0]  ph_coef;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_line_position = '0;
    in_base_speed    = '0;
    in_robot_stopped = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    fail_cnt         = 0;
    results_seen     = 0;
    ticks_sent       = 0;
    stopped_sent     = 0;
    reg_writes       = 0;
    steady_flow      = 1'b0;
    tgt_pos          = TARGET_RESET;
    kp               = GAIN_RESET;
    kd               = GAIN_RESET;
    lp_coef          = COEF_RESET;
    last_err         = 0;
    filt_rate        = 0;

    // Directed plan, starting from reset defaults
    plan.push_back(known_row(3500, 0, 0, 0, 0, 0));
    plan.push_back(known_row(8191, 255, 0, 255, 0, 255));
    plan.push_back(known_row(0, -256, 0, -255, -1, -255));
    plan.push_back(known_row(8191, 255, 1, 0, 0, 0));
    plan.push_back(known_row(0, -256, 1, 0, 0, 0));
    plan.push_back(tick_row(3500, 201, 0));
    plan.push_back(tick_row(3600, 200, 0));
    plan.push_back(tick_row(3400, -255, 0));
    plan.push_back(tick_row(4000, 100, 0));
    // zero gains: powers follow the base speed
    plan.push_back(reg_row(REG_GAIN_P, 16'd0));
    plan.push_back(reg_row(REG_GAIN_D, 16'd0));
    plan.push_back(known_row(8191, 77, 0, 77, 77, 0));
    plan.push_back(known_row(0, -256, 0, -255, -255, 0));
    // full gains, frozen filter
    plan.push_back(reg_row(REG_GAIN_P, 16'hFFFF));
    plan.push_back(reg_row(REG_GAIN_D, 16'hFFFF));
    plan.push_back(reg_row(REG_COEF, 16'd0));
    plan.push_back(tick_row(3501, 0, 0));
    plan.push_back(tick_row(3499, 0, 0));
    // filter weight above one, then target jumps drive the rate past its range
    plan.push_back(reg_row(REG_TARGET, 16'hFFFF));
    plan.push_back(reg_row(REG_COEF, 16'd511));
    plan.push_back(tick_row(0, 50, 0));
    plan.push_back(reg_row(REG_TARGET, 16'd0));
    plan.push_back(tick_row(8191, -50, 0));
    plan.push_back(reg_row(REG_TARGET, 16'h1FFF));
    plan.push_back(tick_row(0, 10, 0));
    // tiny gains: truncation toward zero on small sums
    plan.push_back(reg_row(REG_GAIN_P, 16'd1));
    plan.push_back(reg_row(REG_GAIN_D, 16'd1));
    plan.push_back(reg_row(REG_COEF, 16'd256));
    plan.push_back(tick_row(8190, 0, 0));
    plan.push_back(tick_row(8191, 0, 0));
    plan.push_back(tick_row(8000, -1, 0));
    plan.push_back(tick_row(1234, -3, 1));
    plan.push_back(tick_row(5000, 255, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_reg) begin
        drain();
        write_reg(row.idx, row.wdata);
      end else begin
        send_tick(row.pos, row.base, row.stop, gap_draw());
        want = steer_predict(row.pos, row.base, row.stop);
        if (row.fixed) want = row.fixed_drive;
        pending_drive.push_back(want);
      end
    end

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          ph_tgt = '1; ph_kp = 16'hFFFF; ph_kd = 16'hFFFF; ph_coef = 9'd511;
        end
        1: begin
          ph_tgt = '0; ph_kp = 16'd0; ph_kd = 16'd0; ph_coef = 9'd0;
        end
        default: begin
          r = $urandom_range(0, 99);
          ph_tgt = (r < 10) ? '0 : (r < 20) ? '1 : POS_W'($urandom_range(0, 8191));
          ph_kp = gain_draw();
          ph_kd = gain_draw();
          r = $urandom_range(0, 99);
          if (r < 15)      ph_coef = 9'd256;
          else if (r < 25) ph_coef = 9'($urandom_range(257, 511));
          else if (r < 35) ph_coef = 9'd0;
          else             ph_coef = 9'($urandom_range(1, 255));
        end
      endcase
      // unused upper data bits carry noise
      w = 16'($urandom_range(0, 65535));
      w[POS_W-1:0] = ph_tgt;
      write_reg(REG_TARGET, w);
      write_reg(REG_GAIN_P, ph_kp);
      write_reg(REG_GAIN_D, ph_kd);
      w = 16'($urandom_range(0, 65535));
      w[8:0] = ph_coef;
      write_reg(REG_COEF, w);
      steady_flow = (ph % 4 == 3);

      for (int i = 0; i < PHASE_TICKS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          p = int'(tgt_pos) + $urandom_range(0, 800) - 400;
        end else if (r < 80) begin
          p = $urandom_range(0, 8191);
        end else if (r < 90) begin
          p = $urandom_range(0, 1) ? 8191 : 0;
        end else begin
          p = int'(tgt_pos) + $urandom_range(0, 6) - 3;
        end
        pos = POS_W'(sat_to(p, 0, 8191));

        r = $urandom_range(0, 99);
        if (r < 15) begin
          tv = $urandom_range(190, 215);
        end else if (r < 25) begin
          case ($urandom_range(0, 5))
            0: tv = -256;
            1: tv = -255;
            2: tv = 255;
            3: tv = 0;
            4: tv = 200;
            default: tv = 201;
          endcase
        end else begin
          tv = $urandom_range(0, 511);
        end
        base = 9'(tv);
        stop = ($urandom_range(0, 7) == 0);

        send_tick(pos, base, stop, steady_flow ? 0 : gap_draw());
        pending_drive.push_back(steer_predict(pos, base, stop));
      end
    end

    // Let the last results out, then allow for the block's latency
    in_valid <= 1'b0;
    steady_flow = 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d control ticks (%0d stopped), checked %0d results, %0d reg writes",
             ticks_sent, stopped_sent, results_seen, reg_writes);
    $display("Settings ranged from zero to full gains, frozen to over-unity filter weights");
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
